// ----- design/eds_pkg.sv -----
package eds_pkg;

  typedef enum logic [2:0] {
    CMD_WRITE_BOTH = 3'd0,
    CMD_WRITE_LOW  = 3'd1,
    CMD_WRITE_HIGH = 3'd2,
    CMD_CLEAR_BOTH = 3'd3,
    CMD_CLEAR_LOW  = 3'd4,
    CMD_CLEAR_HIGH = 3'd5
  } cmd_t;

  localparam int CMD_W = 3;
  localparam int VALUE_W = 32;
  localparam int GROUP_W = 32;

  // Division by ten thousand: multiply by 2^45 / 10000, rounded up, then shift right by 45.
  localparam logic [31:0] DIV10K_MAGIC = 32'hD1B7_1759;
  localparam int DIV10K_SHIFT = 45;
  localparam int QUOT_W = 19;
  localparam int QUOT_HI_W = 6;
  localparam int NUM_W = 14;
  localparam logic [13:0] TEN_THOUSAND = 14'd10000;

  function automatic logic [7:0] seg_code(input logic [3:0] nibble);
    logic [7:0] code;
    case (nibble)
      4'h0: code = 8'h3F;
      4'h1: code = 8'h06;
      4'h2: code = 8'h5B;
      4'h3: code = 8'h4F;
      4'h4: code = 8'h66;
      4'h5: code = 8'h6D;
      4'h6: code = 8'h7D;
      4'h7: code = 8'h07;
      4'h8: code = 8'h7F;
      4'h9: code = 8'h6F;
      4'hA: code = 8'h77;
      4'hB: code = 8'h7C;
      4'hC: code = 8'h39;
      4'hD: code = 8'h5E;
      4'hE: code = 8'h79;
      4'hF: code = 8'h71;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

// ----- design/eight_digit_seven_segment_writer.sv -----
// Channel  Direction  Signals                    Contents
// s        in         s_tvalid s_tready          s_tdata: value[31:0]
//                     s_tdata s_tuser            s_tuser: cmd[2:0], decimal[3]
// m        out        m_tvalid m_tready m_tdata  m_tdata: low_segments[31:0],
//                                                high_segments[63:32]
//
// One item is accepted per cycle while the output is not stalled; each result passes through
// the seven-stage decimal path, with two reciprocal multiplies by ten thousand, then three
// stages that peel off the decimal digits, and is then held in the output register.
// Each stage moves on when the next one is empty or moving, so bubbles close up under stalls.
// Synchronous reset clears all stage valids and both display registers to all segments off.
module eight_digit_seven_segment_writer
  import eds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value
  input  logic [3:0]  s_tuser,   // cmd[2:0], decimal[3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // low_segments[31:0], high_segments[63:32]
);

  localparam int STAGES = 7;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] adv;
  logic              out_adv;

  logic [VALUE_W-1:0] value_pipe [STAGES];
  cmd_t               cmd_pipe   [STAGES];
  logic               dec_pipe   [STAGES];

  logic [QUOT_W-1:0]    quot;
  logic [QUOT_W-1:0]    quot_d;
  logic [QUOT_HI_W-1:0] quot_hi;
  logic [NUM_W-1:0]     rem_lo;
  logic [NUM_W-1:0]     num     [2];
  logic [3:0]           th4     [2];
  logic [9:0]           r1      [2];
  logic [3:0]           th5     [2];
  logic [3:0]           hu5     [2];
  logic [6:0]           r2      [2];
  logic [15:0]          dig     [2];

  logic [GROUP_W-1:0] low_segments;
  logic [GROUP_W-1:0] high_segments;
  logic [GROUP_W-1:0] low_segments_next;
  logic [GROUP_W-1:0] high_segments_next;

  logic [63:0]        prod1;
  logic [50:0]        prod2;
  logic [31:0]        lo_full;
  logic [QUOT_W-1:0]  hi_full;
  logic [27:0]        th_prod [2];
  logic [3:0]         th_c    [2];
  logic [NUM_W-1:0]   r1_full [2];
  logic [15:0]        hu_prod [2];
  logic [3:0]         hu_c    [2];
  logic [9:0]         r2_full [2];
  logic [14:0]        te_prod [2];
  logic [3:0]         te_c    [2];
  logic [6:0]         on_full [2];

  logic [GROUP_W-1:0] hex_lo;
  logic [GROUP_W-1:0] hex_hi;
  logic [GROUP_W-1:0] dec_lo;
  logic [GROUP_W-1:0] dec_hi;

  always_comb begin
    out_adv = !m_tvalid || m_tready;
    adv[STAGES-1] = !vld[STAGES-1] || out_adv;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign s_tready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      value_pipe[0] <= s_tdata;
      cmd_pipe[0]   <= cmd_t'(s_tuser[2:0]);
      dec_pipe[0]   <= s_tuser[3];
    end
    for (int k = 1; k < STAGES; k++) begin
      if (adv[k]) begin
        value_pipe[k] <= value_pipe[k-1];
        cmd_pipe[k]   <= cmd_pipe[k-1];
        dec_pipe[k]   <= dec_pipe[k-1];
      end
    end
  end

  // Quotient by ten thousand, then the remainders of both groups.
  always_comb begin
    prod1   = {32'd0, value_pipe[0]} * {32'd0, DIV10K_MAGIC};
    prod2   = {32'd0, quot} * {19'd0, DIV10K_MAGIC};
    lo_full = value_pipe[1] - ({13'd0, quot} * {18'd0, TEN_THOUSAND});
    hi_full = quot_d - ({13'd0, quot_hi} * {5'd0, TEN_THOUSAND});
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      quot <= prod1[DIV10K_SHIFT +: QUOT_W];
    end
    if (adv[2]) begin
      quot_d  <= quot;
      quot_hi <= prod2[DIV10K_SHIFT +: QUOT_HI_W];
      rem_lo  <= lo_full[NUM_W-1:0];
    end
    if (adv[3]) begin
      num[0] <= rem_lo;
      num[1] <= (cmd_pipe[2] == CMD_WRITE_BOTH) ? hi_full[NUM_W-1:0] : rem_lo;
    end
  end

  // Decimal digits of each four-digit number: thousands, then hundreds, then tens and ones together.
  always_comb begin
    for (int g = 0; g < 2; g++) begin
      th_prod[g] = {14'd0, num[g]} * 28'd8389;
      th_c[g]    = th_prod[g][26:23];
      r1_full[g] = num[g] - ({10'd0, th_c[g]} * 14'd1000);
      hu_prod[g] = {6'd0, r1[g]} * 16'd41;
      hu_c[g]    = hu_prod[g][15:12];
      r2_full[g] = r1[g] - ({6'd0, hu_c[g]} * 10'd100);
      te_prod[g] = {8'd0, r2[g]} * 15'd205;
      te_c[g]    = te_prod[g][14:11];
      on_full[g] = r2[g] - ({3'd0, te_c[g]} * 7'd10);
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < 2; g++) begin
      if (adv[4]) begin
        th4[g] <= th_c[g];
        r1[g]  <= r1_full[g][9:0];
      end
      if (adv[5]) begin
        th5[g] <= th4[g];
        hu5[g] <= hu_c[g];
        r2[g]  <= r2_full[g][6:0];
      end
      if (adv[6]) begin
        dig[g] <= {th5[g], hu5[g], te_c[g], on_full[g][3:0]};
      end
    end
  end

  eds_seg_group u_hex_lo (.nibbles(value_pipe[STAGES-1][15:0]),  .segments(hex_lo));
  eds_seg_group u_hex_hi (.nibbles(value_pipe[STAGES-1][31:16]), .segments(hex_hi));
  eds_seg_group u_dec_lo (.nibbles(dig[0]), .segments(dec_lo));
  eds_seg_group u_dec_hi (.nibbles(dig[1]), .segments(dec_hi));

  always_comb begin
    low_segments_next  = low_segments;
    high_segments_next = high_segments;
    case (cmd_pipe[STAGES-1])
      CMD_WRITE_BOTH: begin
        low_segments_next  = dec_pipe[STAGES-1] ? dec_lo : hex_lo;
        high_segments_next = dec_pipe[STAGES-1] ? dec_hi : hex_hi;
      end
      CMD_WRITE_LOW: begin
        low_segments_next = dec_pipe[STAGES-1] ? dec_lo : hex_lo;
      end
      CMD_WRITE_HIGH: begin
        high_segments_next = dec_pipe[STAGES-1] ? dec_hi : hex_lo;
      end
      CMD_CLEAR_BOTH: begin
        low_segments_next  = '0;
        high_segments_next = '0;
      end
      CMD_CLEAR_LOW: begin
        low_segments_next = '0;
      end
      CMD_CLEAR_HIGH: begin
        high_segments_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid      <= 1'b0;
      low_segments  <= '0;
      high_segments <= '0;
    end else if (vld[STAGES-1] && out_adv) begin
      m_tvalid      <= 1'b1;
      low_segments  <= low_segments_next;
      high_segments <= high_segments_next;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {high_segments, low_segments};

endmodule

// ----- design/eds_seg_group.sv -----
module eds_seg_group
  import eds_pkg::*;
(
  input  logic [15:0] nibbles,  // digit 0 in the lowest nibble
  output logic [31:0] segments  // digit 0 in the lowest byte
);

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      segments[d*8 +: 8] = seg_code(nibbles[d*4 +: 4]);
    end
  end

endmodule

// ----- tb/eds_checker.sv -----
`timescale 1ns / 1ps

module eds_checker
  import eds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [3:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [31:0] high_segments;
    logic [31:0] low_segments;
  } display_t;

  // Segment patterns of the sixteen digits, digit 0 in the lowest byte.
  localparam logic [127:0] GLYPHS = {
    8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
    8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  display_t shown;
  display_t displays_due[$];

  function automatic logic [7:0] glyph(input int unsigned digit);
    return GLYPHS[8*digit +: 8];
  endfunction

  function automatic logic [31:0] hex_glyphs(input logic [15:0] number);
    return {glyph(number[15:12]), glyph(number[11:8]), glyph(number[7:4]), glyph(number[3:0])};
  endfunction

  function automatic logic [31:0] dec_glyphs(input logic [31:0] number);
    int unsigned rest;
    rest = number % 10000;
    return {glyph(rest / 1000), glyph((rest / 100) % 10), glyph((rest / 10) % 10),
            glyph(rest % 10)};
  endfunction

  function automatic logic [31:0] group_glyphs(input logic [31:0] number, input logic dec);
    return dec ? dec_glyphs(number) : hex_glyphs(number[15:0]);
  endfunction

  function automatic display_t apply_command(input display_t cur, input logic [3:0] user,
                                             input logic [31:0] number);
    display_t nxt;
    logic     dec;
    nxt = cur;
    dec = user[3];
    case (user[2:0])
      CMD_WRITE_BOTH: begin
        if (dec) begin
          nxt.low_segments  = dec_glyphs(number % 10000);
          nxt.high_segments = dec_glyphs(number / 10000);
        end else begin
          nxt.low_segments  = hex_glyphs(number[15:0]);
          nxt.high_segments = hex_glyphs(number[31:16]);
        end
      end
      CMD_WRITE_LOW:  nxt.low_segments = group_glyphs(number, dec);
      CMD_WRITE_HIGH: nxt.high_segments = group_glyphs(number, dec);
      CMD_CLEAR_BOTH: nxt = '0;
      CMD_CLEAR_LOW:  nxt.low_segments = '0;
      CMD_CLEAR_HIGH: nxt.high_segments = '0;
      default: ;
    endcase
    return nxt;
  endfunction

  always @(posedge clk) begin
    display_t seen;
    display_t want;
    if (rst) begin
      shown = '0;
      displays_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen = m_tdata;
        if (displays_due.size() == 0) begin
          $error("result with no item outstanding: %h", m_tdata);
          mismatches++;
        end else begin
          want = displays_due.pop_front();
          if (seen.low_segments !== want.low_segments) begin
            $error("low_segments: expected %h, actual %h", want.low_segments,
                   seen.low_segments);
            mismatches++;
          end
          if (seen.high_segments !== want.high_segments) begin
            $error("high_segments: expected %h, actual %h", want.high_segments,
                   seen.high_segments);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        shown = apply_command(shown, s_tuser, s_tdata);
        displays_due.push_back(shown);
      end
    end
    pending <= displays_due.size();
  end

endmodule

// ----- tb/tb_eight_digit_seven_segment_writer.sv -----
`timescale 1ns / 1ps

module tb_eight_digit_seven_segment_writer;
  import eds_pkg::*;

  localparam logic [2:0] CMD_RESERVED_6 = 3'd6;
  localparam logic [2:0] CMD_RESERVED_7 = 3'd7;
  localparam int RANDOM_ITEMS = 850;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        calm = 1'b0;
  int          mismatches;
  int          pending;

  always #10 clk = ~clk;

  eight_digit_seven_segment_writer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  eds_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 38);
  end

  task automatic send_command(input logic [2:0] code, input logic [31:0] number,
                              input logic dec);
    while (!calm && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= number;
    s_tuser  <= {dec, code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom_range(9999);
      1: return 32'($urandom_range(429496)) * 32'd10000 - 32'd1 + 32'($urandom_range(2));
      2: return 32'd99_999_990 + 32'($urandom_range(20));
      3: return $urandom_range(16'hFFFF);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] pick_command();
    int unsigned r;
    r = $urandom_range(19);
    if (r < 12) begin
      case (r % 3)
        0: return CMD_WRITE_BOTH;
        1: return CMD_WRITE_LOW;
        default: return CMD_WRITE_HIGH;
      endcase
    end else if (r < 18) begin
      case (r % 3)
        0: return CMD_CLEAR_BOTH;
        1: return CMD_CLEAR_LOW;
        default: return CMD_CLEAR_HIGH;
      endcase
    end
    return (r == 18) ? CMD_RESERVED_6 : CMD_RESERVED_7;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_command(CMD_RESERVED_6, 32'hFFFF_FFFF, 1'b1);
    send_command(CMD_WRITE_BOTH, 32'hFFFF_FFFF, 1'b0);
    send_command(CMD_WRITE_BOTH, 32'h0000_0000, 1'b0);
    send_command(CMD_WRITE_BOTH, 32'hFFFF_FFFF, 1'b1);
    send_command(CMD_WRITE_BOTH, 32'd99_999_999, 1'b1);
    send_command(CMD_WRITE_BOTH, 32'd100_000_000, 1'b1);
    send_command(CMD_WRITE_BOTH, 32'd12_345_678, 1'b1);
    send_command(CMD_WRITE_BOTH, 32'h0000_0000, 1'b1);
    send_command(CMD_WRITE_BOTH, 32'h89AB_CDEF, 1'b0);
    send_command(CMD_WRITE_LOW, 32'hABCD_EF12, 1'b0);
    send_command(CMD_WRITE_LOW, 32'd9999, 1'b1);
    send_command(CMD_WRITE_LOW, 32'd10000, 1'b1);
    send_command(CMD_WRITE_LOW, 32'hFFFF_FFFF, 1'b1);
    send_command(CMD_WRITE_HIGH, 32'h1234_5678, 1'b0);
    send_command(CMD_WRITE_HIGH, 32'hFFFF_FFFF, 1'b1);
    send_command(CMD_WRITE_HIGH, 32'h0000_FEDC, 1'b0);
    send_command(CMD_RESERVED_7, 32'h5555_AAAA, 1'b0);
    send_command(CMD_CLEAR_LOW, 32'hFFFF_FFFF, 1'b1);
    send_command(CMD_CLEAR_HIGH, 32'h1234_5678, 1'b0);
    send_command(CMD_WRITE_BOTH, 32'hFEDC_BA98, 1'b0);
    send_command(CMD_CLEAR_BOTH, 32'hFFFF_FFFF, 1'b1);
    send_command(CMD_WRITE_BOTH, 32'd10000, 1'b1);
    send_command(CMD_CLEAR_BOTH, 32'h0000_0000, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) calm <= 1'b1;
      if (n == 450) calm <= 1'b0;
      send_command(pick_command(), pick_value(), 1'($urandom_range(1)));
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
